FILE: hw/rtl/kphr_pkg.sv
// shared types, constants and register codes for the key press/hold/release tracker
package kphr_pkg;

  localparam int NUM_KEYS = 8;
  localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int IDX_W   = 3;
  localparam int COUNT_W = 8;
  localparam int TIME_W  = 32;
  localparam int STATE_W = 3;
  localparam int THR_W   = 8;
  localparam int PER_W   = 16;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TO  = 2'd3;

  // per-key state codes
  localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_PRESSED  = 3'd1;
  localparam logic [STATE_W-1:0] ST_HOLDTIME = 3'd2;
  localparam logic [STATE_W-1:0] ST_HOLD     = 3'd3;
  localparam logic [STATE_W-1:0] ST_RELEASED = 3'd4;

  // item modes
  localparam logic MODE_SCAN  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [THR_W-1:0] PRESS_THR_RST   = 8'd8;
  localparam logic [THR_W-1:0] RELEASE_THR_RST = 8'd2;
  localparam logic [PER_W-1:0] HOLD_PERIOD_RST = 16'd1000;
  localparam logic [PER_W-1:0] RELEASE_TO_RST  = 16'd500;

  typedef struct packed {
    logic [STATE_W-1:0] key_mode;
    logic [TIME_W-1:0]  hold_start;
    logic [TIME_W-1:0]  release_start;
  } entry_t;

  typedef struct packed {
    logic [THR_W-1:0] press_threshold;
    logic [THR_W-1:0] release_threshold;
    logic [PER_W-1:0] hold_period;
    logic [PER_W-1:0] release_timeout;
  } cfg_t;

endpackage

FILE: hw/rtl/kphr_key_ram.sv
// per-key state memory with registered read and reset-cleared valid bits
module kphr_key_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [kphr_pkg::KEY_AW-1:0] rd_addr,
  output kphr_pkg::entry_t            rd_data,
  input  logic                        wr_en,
  input  logic [kphr_pkg::KEY_AW-1:0] wr_addr,
  input  kphr_pkg::entry_t            wr_data
);

  kphr_pkg::entry_t                  mem [kphr_pkg::NUM_KEYS];
  logic [kphr_pkg::NUM_KEYS-1:0]     valid;
  kphr_pkg::entry_t                  rd_q;
  logic                              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as its reset value
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

FILE: hw/rtl/kphr_update.sv
// next-state and result logic for one key scan or query
module kphr_update (
  input  kphr_pkg::entry_t                 cur,
  input  kphr_pkg::cfg_t                   cfg,
  input  logic                             mode,
  input  logic [kphr_pkg::COUNT_W-1:0]     press_count,
  input  logic [kphr_pkg::TIME_W-1:0]      now_ms,
  output kphr_pkg::entry_t                 nxt,
  output logic [kphr_pkg::STATE_W-1:0]     result
);

  logic [kphr_pkg::TIME_W-1:0] hold_elapsed;
  logic [kphr_pkg::TIME_W-1:0] rel_elapsed;
  logic                        hold_done;
  logic                        rel_done;
  logic                        is_release;

  // wrapping differences
  assign hold_elapsed = now_ms - cur.hold_start;
  assign rel_elapsed  = now_ms - cur.release_start;
  assign hold_done  = hold_elapsed >=
                      {{(kphr_pkg::TIME_W-kphr_pkg::PER_W){1'b0}}, cfg.hold_period};
  assign rel_done   = rel_elapsed >=
                      {{(kphr_pkg::TIME_W-kphr_pkg::PER_W){1'b0}}, cfg.release_timeout};
  assign is_release = press_count < cfg.release_threshold;

  always_comb begin
    nxt    = cur;
    result = kphr_pkg::ST_IDLE;
    if (mode == kphr_pkg::MODE_SCAN) begin
      unique case (cur.key_mode)
        kphr_pkg::ST_IDLE: begin
          if (press_count >= cfg.press_threshold) begin
            nxt.key_mode   = kphr_pkg::ST_PRESSED;
            nxt.hold_start = now_ms;
          end
        end
        kphr_pkg::ST_PRESSED, kphr_pkg::ST_HOLD: begin
          if (is_release) begin
            nxt.key_mode      = kphr_pkg::ST_RELEASED;
            nxt.release_start = now_ms;
          end else if (hold_done) begin
            nxt.key_mode = kphr_pkg::ST_HOLDTIME;
          end
        end
        kphr_pkg::ST_HOLDTIME: begin
          if (is_release) begin
            nxt.key_mode      = kphr_pkg::ST_RELEASED;
            nxt.release_start = now_ms;
          end
        end
        kphr_pkg::ST_RELEASED: begin
          if (rel_done) begin
            nxt.key_mode = kphr_pkg::ST_IDLE;
          end
        end
        default: begin
          nxt.key_mode = kphr_pkg::ST_IDLE;
        end
      endcase
      result = nxt.key_mode;
    end else begin
      // query returns the stored code and consumes it
      result = cur.key_mode;
      unique case (cur.key_mode)
        kphr_pkg::ST_PRESSED, kphr_pkg::ST_HOLD: begin
          nxt.key_mode = kphr_pkg::ST_HOLD;
        end
        kphr_pkg::ST_HOLDTIME: begin
          nxt.key_mode   = kphr_pkg::ST_HOLD;
          nxt.hold_start = now_ms;
        end
        default: begin
          nxt.key_mode = kphr_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/key_press_hold_release_fsm.sv
// key press/hold/release tracker: per-key state in a memory, read-modify-write per transaction
// a transaction's key entry is read into a register, then updated and written back as its result is registered
// a new transaction is taken only after the previous one has written back its key entry;
//   a stalled result holds the update stage
// reset: synchronous rst clears the key valid bits, so every key reads as not pressed with
//   zero timestamps; configuration registers return to 8, 2, 1000 and 500
module key_press_hold_release_fsm (
  input  logic                              clk,
  input  logic                              rst,
  // stream input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: mode[0], key_index[3:1], press_count[11:4], now_ms[43:12], zero pad
  input  logic [kphr_pkg::S_TDATA_W-1:0]    s_tdata,
  // stream output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata from bit 0: key_state[2:0], zero pad
  output logic [kphr_pkg::M_TDATA_W-1:0]    m_tdata,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [kphr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kphr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // input field unpacking
  logic                             in_mode;
  logic [kphr_pkg::IDX_W-1:0]       in_key;
  logic [kphr_pkg::COUNT_W-1:0]     in_count;
  logic [kphr_pkg::TIME_W-1:0]      in_now;
  logic                             in_range;

  assign in_mode  = s_tdata[0];
  assign in_key   = s_tdata[3:1];
  assign in_count = s_tdata[11:4];
  assign in_now   = s_tdata[43:12];
  // out-of-range keys touch nothing and report not pressed
  assign in_range = {1'b0, in_key} < (kphr_pkg::IDX_W+1)'(kphr_pkg::NUM_KEYS);

  // configuration registers
  kphr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold   <= kphr_pkg::PRESS_THR_RST;
      cfg.release_threshold <= kphr_pkg::RELEASE_THR_RST;
      cfg.hold_period       <= kphr_pkg::HOLD_PERIOD_RST;
      cfg.release_timeout   <= kphr_pkg::RELEASE_TO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kphr_pkg::REG_PRESS_THR:   cfg.press_threshold   <= cfg_data[kphr_pkg::THR_W-1:0];
        kphr_pkg::REG_RELEASE_THR: cfg.release_threshold <= cfg_data[kphr_pkg::THR_W-1:0];
        kphr_pkg::REG_HOLD_PERIOD: cfg.hold_period       <= cfg_data;
        kphr_pkg::REG_RELEASE_TO:  cfg.release_timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

  // update stage: item held while its key entry is read and then written back
  logic                             busy;
  logic                             item_mode;
  logic [kphr_pkg::IDX_W-1:0]       item_key;
  logic [kphr_pkg::COUNT_W-1:0]     item_count;
  logic [kphr_pkg::TIME_W-1:0]      item_now;
  logic                             item_range;

  logic                             accept;
  logic                             out_free;
  logic                             retire;

  kphr_pkg::entry_t                 cur_entry;
  kphr_pkg::entry_t                 nxt_entry;
  logic [kphr_pkg::STATE_W-1:0]     upd_result;
  logic [kphr_pkg::STATE_W-1:0]     key_state;

  // new transactions only when no read-modify-write is open, so a read never
  // overlaps the write-back of the same entry
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign retire   = busy && out_free;

  kphr_key_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_key[kphr_pkg::KEY_AW-1:0]),
    .rd_data (cur_entry),
    .wr_en   (retire && item_range),
    .wr_addr (item_key[kphr_pkg::KEY_AW-1:0]),
    .wr_data (nxt_entry)
  );

  kphr_update u_update (
    .cur         (cur_entry),
    .cfg         (cfg),
    .mode        (item_mode),
    .press_count (item_count),
    .now_ms      (item_now),
    .nxt         (nxt_entry),
    .result      (upd_result)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= in_mode;
      item_key   <= in_key;
      item_count <= in_count;
      item_now   <= in_now;
      item_range <= in_range;
    end
    if (retire) begin
      key_state <= item_range ? upd_result : kphr_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (retire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(kphr_pkg::M_TDATA_W-kphr_pkg::STATE_W){1'b0}}, key_state};

endmodule

FILE: bench/tb_key_press_hold_release_fsm.sv
// self-checking testbench for the key press/hold/release tracker
`timescale 1ns / 1ps

module tb_key_press_hold_release_fsm;
  import kphr_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int RESET_CYC  = 11;
  localparam int LIMIT_CYC  = 200000;
  localparam int LONG_STALL = 300;
  localparam int DRAIN_CYC  = 4;     // settle margin after the last result
  localparam int PHASE_LEN  = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_press_hold_release_fsm dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // shadow copy of the key table and the registers, advanced on every accepted item
  logic [STATE_W-1:0] shadow_state [NUM_KEYS];
  logic [TIME_W-1:0]  shadow_hold_t [NUM_KEYS];
  logic [TIME_W-1:0]  shadow_rel_t [NUM_KEYS];
  logic [THR_W-1:0]   press_thr = PRESS_THR_RST;
  logic [THR_W-1:0]   rel_thr   = RELEASE_THR_RST;
  logic [PER_W-1:0]   hold_per  = HOLD_PERIOD_RST;
  logic [PER_W-1:0]   rel_to    = RELEASE_TO_RST;

  // key states still owed by the block, oldest first
  logic [STATE_W-1:0] pending_states [$];

  int send_idle_pct = 12;
  int recv_idle_pct = 74;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int cycle_count   = 0;
  logic [TIME_W-1:0] sim_ms = '0;

  // toggled by a test to ask the receiver for one long hold-off
  logic stall_kick = 1'b0;
  logic kick_seen  = 1'b0;
  int   hold_left  = 0;

  initial begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      shadow_state[i]  = ST_IDLE;
      shadow_hold_t[i] = '0;
      shadow_rel_t[i]  = '0;
    end
  end

  // next key state for one item; scans return the new state, queries the prior one
  function automatic logic [STATE_W-1:0] step_key(input logic mode,
                                                  input logic [IDX_W-1:0] k,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic [TIME_W-1:0] t);
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] nxt;
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  gone;
    cur  = shadow_state[k];
    nxt  = cur;
    held = t - shadow_hold_t[k];   // modulo 2^32, survives a wrap
    gone = t - shadow_rel_t[k];
    if (mode == MODE_SCAN) begin
      case (cur)
        ST_IDLE: begin
          if (cnt >= press_thr) begin
            nxt = ST_PRESSED;
            shadow_hold_t[k] = t;
          end
        end
        ST_PRESSED, ST_HOLD: begin
          if (cnt < rel_thr) begin
            nxt = ST_RELEASED;
            shadow_rel_t[k] = t;
          end else if (held >= TIME_W'(hold_per)) begin
            nxt = ST_HOLDTIME;
          end
        end
        ST_HOLDTIME: begin
          if (cnt < rel_thr) begin
            nxt = ST_RELEASED;
            shadow_rel_t[k] = t;
          end
        end
        ST_RELEASED: begin
          if (gone >= TIME_W'(rel_to)) nxt = ST_IDLE;
        end
        default: nxt = ST_IDLE;
      endcase
      shadow_state[k] = nxt;
      return nxt;
    end
    // query consumes the state
    case (cur)
      ST_PRESSED, ST_HOLD: nxt = ST_HOLD;
      ST_HOLDTIME: begin
        nxt = ST_HOLD;
        shadow_hold_t[k] = t;   // hold timer restarts
      end
      default: nxt = ST_IDLE;
    endcase
    shadow_state[k] = nxt;
    return cur;
  endfunction

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYC) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_states.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random ready, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (stall_kick != kick_seen) begin
      kick_seen <= stall_kick;
      hold_left <= LONG_STALL;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every result transaction with the oldest owed state
  always @(posedge clk) begin : check_results
    logic [STATE_W-1:0] want_state;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_states.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, actual key_state=%0d",
                 $time, m_tdata[STATE_W-1:0]);
        errors++;
      end else begin
        want_state = pending_states.pop_front();
        if (m_tdata[STATE_W-1:0] !== want_state) begin
          $display("%0t: key_state mismatch: expected %0d, actual %0d", $time,
                   want_state, m_tdata[STATE_W-1:0]);
          errors++;
        end
      end
    end
  end

  // offer one item, hold it until accepted, then record what it must return
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] k,
                           input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, t, cnt, k, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_states.push_back(step_key(mode, k, cnt, t));
    items_sent++;
  endtask

  // stop offering and wait for every owed result, then let the pipe settle
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PRESS_THR:   press_thr = val[THR_W-1:0];
      REG_RELEASE_THR: rel_thr   = val[THR_W-1:0];
      REG_HOLD_PERIOD: hold_per  = val;
      REG_RELEASE_TO:  rel_to    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(input logic [THR_W-1:0] p, input logic [THR_W-1:0] r,
                              input logic [PER_W-1:0] h, input logic [PER_W-1:0] to);
    write_reg(REG_PRESS_THR, CFG_DATA_W'(p));
    write_reg(REG_RELEASE_THR, CFG_DATA_W'(r));
    write_reg(REG_HOLD_PERIOD, h);
    write_reg(REG_RELEASE_TO, to);
    settings_used++;
  endtask

  // random item: mostly keys pressed and let go over advancing time, some noise
  task automatic send_random_item(input int step_max);
    int   roll;
    int   pick;
    logic mode;
    logic [COUNT_W-1:0] cnt;
    roll = $urandom_range(99);
    if (roll < 4) sim_ms = $urandom();
    else if (roll < 6) sim_ms = sim_ms - $urandom_range(2000);
    else sim_ms = sim_ms + $urandom_range(step_max);
    mode = ($urandom_range(99) < 20) ? MODE_QUERY : MODE_SCAN;
    pick = $urandom_range(99);
    if (pick < 40) cnt = COUNT_W'($urandom_range(255, press_thr));
    else if (pick < 75 && rel_thr != 0) cnt = COUNT_W'($urandom_range(rel_thr - 1, 0));
    else cnt = COUNT_W'($urandom_range(255));
    send_item(mode, IDX_W'($urandom_range(NUM_KEYS - 1)), cnt, sim_ms);
  endtask

  task automatic run_phase(input logic [THR_W-1:0] p, input logic [THR_W-1:0] r,
                           input logic [PER_W-1:0] h, input logic [PER_W-1:0] to,
                           input int send_pct, input int recv_pct, input bit squeeze);
    int step_max;
    load_setting(p, r, h, to);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    step_max = ((h > to) ? int'(h) : int'(to)) / 4 + 20;
    if (squeeze) stall_kick <= ~stall_kick;
    repeat (PHASE_LEN) send_random_item(step_max);
    drain();
  endtask

  // reset values: keys 0 and 7 query idle, key 1 presses at the threshold of 8
  task automatic test_reset_state;
    send_item(MODE_QUERY, 3'd0, 8'd0, 32'd100);
    send_item(MODE_QUERY, 3'd7, 8'hff, 32'd100);
    send_item(MODE_SCAN, 3'd1, 8'd7, 32'd100);
    send_item(MODE_SCAN, 3'd1, 8'd8, 32'd100);
  endtask

  // key 1 reaches hold time at exactly the hold period, query restarts the timer
  task automatic test_hold_cycle;
    send_item(MODE_SCAN, 3'd1, 8'd255, 32'd1099);
    send_item(MODE_SCAN, 3'd1, 8'd2, 32'd1100);
    send_item(MODE_SCAN, 3'd1, 8'd100, 32'd1200);
    send_item(MODE_QUERY, 3'd1, 8'd0, 32'd1300);
    send_item(MODE_QUERY, 3'd1, 8'd0, 32'd1301);
    send_item(MODE_SCAN, 3'd1, 8'd9, 32'd2299);
    send_item(MODE_SCAN, 3'd1, 8'd9, 32'd2300);
  endtask

  // release, timeout at exactly the limit, and a query that consumes a release
  task automatic test_release_timeout;
    send_item(MODE_SCAN, 3'd1, 8'd1, 32'd2400);
    send_item(MODE_SCAN, 3'd1, 8'd255, 32'd2899);
    send_item(MODE_SCAN, 3'd1, 8'd255, 32'd2900);
    send_item(MODE_SCAN, 3'd2, 8'd8, 32'd3000);
    send_item(MODE_QUERY, 3'd2, 8'd0, 32'd3000);
    send_item(MODE_SCAN, 3'd2, 8'd0, 32'd3001);
    send_item(MODE_QUERY, 3'd2, 8'd0, 32'd3002);
    send_item(MODE_QUERY, 3'd2, 8'd0, 32'd3003);
  endtask

  // elapsed time taken across the 32-bit wrap of the millisecond clock
  task automatic test_time_wrap;
    send_item(MODE_SCAN, 3'd3, 8'd200, 32'hffff_fe00);
    send_item(MODE_SCAN, 3'd3, 8'd200, 32'h0000_01e7);
    send_item(MODE_SCAN, 3'd3, 8'd200, 32'h0000_01e8);
    send_item(MODE_SCAN, 3'd3, 8'd0, 32'hffff_ffff);
    send_item(MODE_SCAN, 3'd3, 8'd0, 32'h0000_01f3);
    drain();
  endtask

  // register settings from defaults to both extremes, with idle on either side and with none
  task automatic test_random_traffic;
    run_phase(8'd8, 8'd2, 16'd1000, 16'd500, 12, 74, 1'b0);
    run_phase(8'd0, 8'd255, 16'd0, 16'd0, 12, 74, 1'b0);
    run_phase(8'd255, 8'd0, 16'hffff, 16'hffff, 74, 12, 1'b0);
    run_phase(THR_W'($urandom_range(255)), THR_W'($urandom_range(255)),
              PER_W'($urandom_range(65535)), PER_W'($urandom_range(65535)), 0, 0, 1'b0);
    run_phase(8'd20, 8'd5, 16'd50, 16'd30, 0, 0, 1'b0);
    run_phase(THR_W'($urandom_range(255)), THR_W'($urandom_range(255)),
              PER_W'($urandom_range(3000)), PER_W'($urandom_range(3000)), 0, 0, 1'b0);
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure;
    run_phase(8'd128, 8'd64, 16'd300, 16'd200, 0, 0, 1'b1);
  endtask

  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_hold_cycle();
    test_release_timeout();
    test_time_wrap();
    test_random_traffic();
    test_output_backpressure();
    $display("run covered %0d transactions in, %0d results out, over %0d register settings",
             items_sent, results_seen, settings_used);
    $display("scan and query on all keys, hold and release limits, clock wrap, long stall");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
